// ===== sv/salwc_pkg.sv =====
package salwc_pkg;

  // Defaults for the top-level parameters.
  localparam int SETS_DEF        = 32;
  localparam int WAYS_DEF        = 2;
  localparam int BLOCK_BYTES_DEF = 16;
  localparam int ADDR_BITS_DEF   = 32;

  // Width of the address field on the channels.
  localparam int ADDR_W = 32;

  // Next-level request codes.
  typedef logic [1:0] req_t;
  localparam req_t REQ_NONE    = 2'd0;
  localparam req_t REQ_READ    = 2'd1;
  localparam req_t REQ_WB_READ = 2'd2;

  // Controller state: a clearing pass over the line store, then normal operation.
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  // Rounded-down base-two logarithm, evaluated at elaboration.
  function automatic int floor_log2(input int v);
    int n;
    n = 0;
    for (int i = 1; i < 31; i++) begin
      if (v >= (1 << i)) begin
        n = i;
      end
    end
    return n;
  endfunction

endpackage

// ===== sv/salwc_if.sv =====
interface salwc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [salwc_pkg::ADDR_W-1:0] address;

  modport source(output valid, output command, output address, input ready);
  modport sink(input valid, input command, input address, output ready);
endinterface

interface salwc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  salwc_pkg::req_t              next_level_request;
  logic [salwc_pkg::ADDR_W-1:0] evict_address;

  modport source(output valid, output hit, output next_level_request,
                 output evict_address, input ready);
  modport sink(input valid, input hit, input next_level_request,
               input evict_address, output ready);
endinterface

// ===== sv/set_assoc_lru_writeback_cache.sv =====
// Channel   Direction  Handshake          Contents
// in_ch     input      valid / ready      command (0 read, 1 write), address
// out_ch    output     valid / ready      hit, next_level_request, evict_address
//
// One transaction per cycle is sustained while out_ch is ready. An accepted
// transaction's row is read from the line store into the update stage, where
// the tag compare and row update run and the result goes to the output
// register; one row read and one row write per transaction, on separate ports
// of the line store, set that throughput. After reset the store is cleared
// one set per cycle, all 2**floor(log2(SETS)) rows, and in_ch.ready stays low
// meanwhile. A stalled out_ch holds its result; in_ch keeps taking
// transactions until the update stage also fills, then ready drops.
module set_assoc_lru_writeback_cache #(
  parameter int SETS        = salwc_pkg::SETS_DEF,
  parameter int WAYS        = salwc_pkg::WAYS_DEF,
  parameter int BLOCK_BYTES = salwc_pkg::BLOCK_BYTES_DEF,
  parameter int ADDR_BITS   = salwc_pkg::ADDR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  salwc_in_if.sink   in_ch,
  salwc_out_if.source out_ch
);

  localparam int AW       = salwc_pkg::ADDR_W;
  localparam int OFF_BITS = salwc_pkg::floor_log2(BLOCK_BYTES);
  localparam int SET_BITS = salwc_pkg::floor_log2(SETS);
  localparam int NROWS    = 1 << SET_BITS;
  localparam int SET_IW   = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_SH   = OFF_BITS + SET_BITS;
  localparam int AGE_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WIDX_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [AW-1:0] ADDR_MASK =
    (ADDR_BITS >= AW) ? {AW{1'b1}} : AW'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [AW-1:0]     SET_MASK = AW'(NROWS - 1);
  localparam logic [SET_IW-1:0] LAST_ROW = SET_IW'(NROWS - 1);
  localparam logic [AGE_W-1:0]  OLDEST   = AGE_W'(WAYS - 1);

  // One row of the line store holds every way of a set. The tag is not kept
  // separately: it is the upper part of the stored fill address.
  typedef struct packed {
    logic [WAYS-1:0]                valid;
    logic [WAYS-1:0]                dirty;
    logic [WAYS-1:0][AGE_W-1:0]     age;
    logic [WAYS-1:0][AW-1:0]        fill;
  } row_t;

  // Control state.
  salwc_pkg::state_t state_r, state_nxt;
  logic [SET_IW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              clr_active;
  logic              run_active;

  // Update stage and output register.
  logic              s1_vld_r, s1_vld_nxt;
  logic              s1_cmd_r;
  logic [AW-1:0]     s1_addr_r;
  logic [SET_IW-1:0] s1_set_r;
  logic              fwd_r;
  row_t              wrow_r;
  logic              out_vld_r, out_vld_nxt;
  logic              out_hit_r;
  salwc_pkg::req_t   out_req_r;
  logic [AW-1:0]     out_wb_r;

  // Line store.
  row_t              mem [NROWS];
  row_t              rd_row_r;
  logic              mem_we;
  logic [SET_IW-1:0] mem_wa;
  row_t              mem_wd;

  logic              accept;
  logic              s1_adv;
  logic [AW-1:0]     in_addr_m;
  logic [SET_IW-1:0] in_set;

  row_t              row;
  row_t              new_row;
  row_t              clr_row;
  logic [WAYS-1:0]   hit_vec;
  logic              hit_any;
  logic [WIDX_W-1:0] hit_way;
  logic              empty_any;
  logic [WIDX_W-1:0] empty_way;
  logic [WIDX_W-1:0] old_way;
  logic [WIDX_W-1:0] victim;
  logic [WIDX_W-1:0] touch_way;
  logic [AGE_W-1:0]  touch_age;
  salwc_pkg::req_t   req;
  logic [AW-1:0]     wb_addr;

  // ---------------------------------------------------------------------------
  // Clearing pass and run state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      salwc_pkg::ST_CLEAR: begin
        if (clr_cnt_r == LAST_ROW) begin
          state_nxt = salwc_pkg::ST_RUN;
        end
      end
      salwc_pkg::ST_RUN: state_nxt = salwc_pkg::ST_RUN;
      default: state_nxt = salwc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_active = 1'b0;
    run_active = 1'b0;
    case (state_r)
      salwc_pkg::ST_CLEAR: clr_active = 1'b1;
      salwc_pkg::ST_RUN:   run_active = 1'b1;
      default: begin
        clr_active = 1'b0;
        run_active = 1'b0;
      end
    endcase
  end

  assign clr_cnt_nxt = clr_active ? clr_cnt_r + 1'b1 : clr_cnt_r;

  // ---------------------------------------------------------------------------
  // Handshakes. The update stage moves on whenever the output register is
  // empty or being emptied; a new transaction enters behind it in that cycle.
  // ---------------------------------------------------------------------------
  assign s1_adv       = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = run_active && (!s1_vld_r || s1_adv);
  assign accept       = in_ch.valid && in_ch.ready;

  assign s1_vld_nxt  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);
  assign out_vld_nxt = s1_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);

  assign in_addr_m = in_ch.address & ADDR_MASK;
  assign in_set    = SET_IW'((in_addr_m >> OFF_BITS) & SET_MASK);

  // ---------------------------------------------------------------------------
  // Tag compare, victim choice and LRU age update on the row read for the
  // transaction in the update stage. When the previous transaction wrote the
  // same set at the edge this row was read, the written row is used instead.
  // ---------------------------------------------------------------------------
  assign row = fwd_r ? wrow_r : rd_row_r;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = row.valid[w] && ((row.fill[w] >> TAG_SH) == (s1_addr_r >> TAG_SH));
    end
    hit_any = |hit_vec;

    // Lowest-numbered matching, invalid and oldest ways.
    hit_way   = '0;
    empty_way = '0;
    empty_any = 1'b0;
    old_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WIDX_W'(w);
      end
      if (!row.valid[w]) begin
        empty_way = WIDX_W'(w);
        empty_any = 1'b1;
      end
      if (row.age[w] == OLDEST) begin
        old_way = WIDX_W'(w);
      end
    end

    victim    = empty_any ? empty_way : old_way;
    touch_way = hit_any ? hit_way : victim;
    touch_age = row.age[touch_way];

    new_row = row;
    for (int w = 0; w < WAYS; w++) begin
      if (WIDX_W'(w) == touch_way) begin
        new_row.age[w] = '0;
      end else if (row.age[w] < touch_age) begin
        new_row.age[w] = row.age[w] + 1'b1;
      end
    end

    if (hit_any) begin
      new_row.dirty[hit_way] = row.dirty[hit_way] | s1_cmd_r;
    end else begin
      new_row.valid[victim] = 1'b1;
      new_row.dirty[victim] = s1_cmd_r;
      new_row.fill[victim]  = s1_addr_r;
    end

    // A dirty victim exists only when every way was valid.
    if (hit_any) begin
      req = salwc_pkg::REQ_NONE;
    end else if (!empty_any && row.dirty[victim]) begin
      req = salwc_pkg::REQ_WB_READ;
    end else begin
      req = salwc_pkg::REQ_READ;
    end
    wb_addr = (req == salwc_pkg::REQ_WB_READ) ? row.fill[victim] : '0;
  end

  always_comb begin
    clr_row       = '0;
    clr_row.valid = '0;
    clr_row.dirty = '0;
    for (int w = 0; w < WAYS; w++) begin
      clr_row.age[w] = OLDEST;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: one write port shared by the clearing pass and the row update,
  // one read port fed by the accepted address.
  // ---------------------------------------------------------------------------
  assign mem_we = clr_active || s1_adv;
  assign mem_wa = clr_active ? clr_cnt_r : s1_set_r;
  assign mem_wd = clr_active ? clr_row : new_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_row_r <= mem[in_set];
    end
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= salwc_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r  <= in_ch.command;
      s1_addr_r <= in_addr_m;
      s1_set_r  <= in_set;
      fwd_r     <= s1_adv && (s1_set_r == in_set);
    end
    if (s1_adv) begin
      wrow_r    <= new_row;
      out_hit_r <= hit_any;
      out_req_r <= req;
      out_wb_r  <= wb_addr;
    end
  end

  assign out_ch.valid              = out_vld_r;
  assign out_ch.hit                = out_hit_r;
  assign out_ch.next_level_request = out_req_r;
  assign out_ch.evict_address      = out_wb_r;

endmodule

// ===== sv/salwc_checker.sv =====
module salwc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_hit,
  input salwc_pkg::req_t              out_req,
  input logic [salwc_pkg::ADDR_W-1:0] out_wb
);

  // A hit never goes to the next level.
  a_hit_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_req == salwc_pkg::REQ_NONE)
    else $error("hit result carries a next-level request");

  // A miss always reads the next level.
  a_miss_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |->
      (out_req == salwc_pkg::REQ_READ || out_req == salwc_pkg::REQ_WB_READ))
    else $error("miss result without a next-level read");

  // The writeback address is only nonzero alongside a writeback request.
  a_wb_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_req != salwc_pkg::REQ_WB_READ |-> out_wb == '0)
    else $error("writeback address set without a writeback");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_hit) && $stable(out_req) && $stable(out_wb))
    else $error("stalled result changed");

endmodule

bind set_assoc_lru_writeback_cache salwc_checker u_salwc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hit   (out_ch.hit),
  .out_req   (out_ch.next_level_request),
  .out_wb    (out_ch.evict_address)
);

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Geometry of the cache under test; the block is built with its defaults.
  localparam int NUM_SETS   = salwc_pkg::SETS_DEF;
  localparam int NUM_WAYS   = salwc_pkg::WAYS_DEF;
  localparam int OFF_BITS   = $clog2(salwc_pkg::BLOCK_BYTES_DEF);
  localparam int SET_BITS   = $clog2(salwc_pkg::SETS_DEF);
  localparam int TAG_SHIFT  = OFF_BITS + SET_BITS;
  localparam int ADDR_W     = salwc_pkg::ADDR_W;
  localparam int TAG_BITS   = ADDR_W - TAG_SHIFT;
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Run length and watchdog.
  localparam int N_RANDOM    = 1400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  // Receiver back-pressure burst: starts once this many results have come in.
  localparam int HOLD_START  = 120;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] address;
  } access_t;

  typedef struct packed {
    logic              hit;
    salwc_pkg::req_t   next_level_request;
    logic [ADDR_W-1:0] evict_address;
  } lookup_t;

  logic clk;
  logic rst_n;

  salwc_in_if  in_if ();
  salwc_out_if out_if ();

  set_assoc_lru_writeback_cache u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // Shadow copy of the line store, indexed by set and way. Tags and fill
  // addresses are only looked at when the matching valid bit is set.
  logic [TAG_BITS-1:0] shadow_tag   [NUM_SETS][NUM_WAYS];
  logic [ADDR_W-1:0]   shadow_fill  [NUM_SETS][NUM_WAYS];
  bit                  shadow_valid [NUM_SETS][NUM_WAYS];
  bit                  shadow_dirty [NUM_SETS][NUM_WAYS];
  int                  shadow_age   [NUM_SETS][NUM_WAYS];

  access_t pending_q[$];   // accesses waiting to be offered to the cache
  lookup_t lookup_q[$];    // predicted lookup results, oldest first

  int err_cnt    = 0;
  int n_sent     = 0;
  int n_rcvd     = 0;
  int n_hits     = 0;
  int n_fills    = 0;
  int n_wbacks   = 0;
  int cycle_cnt  = 0;
  int hold_left  = 0;
  bit held_off   = 1'b0;

  // The accessed way becomes the youngest; every way younger than it ages by
  // one, so ages that form a permutation of 0 .. WAYS-1 stay one.
  function automatic void make_youngest(int set_idx, int way);
    int old_age;
    old_age = shadow_age[set_idx][way];
    for (int k = 0; k < NUM_WAYS; k++) begin
      if (shadow_age[set_idx][k] < old_age) begin
        shadow_age[set_idx][k]++;
      end
    end
    shadow_age[set_idx][way] = 0;
  endfunction

  // Works out the lookup result of one access and updates the shadow store.
  // The address field is exactly ADDR_BITS wide, so no masking is needed.
  function automatic lookup_t predict_lookup(access_t acc);
    lookup_t             res;
    int                  set_idx;
    int                  way;
    int                  victim;
    bit                  found;
    bit                  have_empty;
    logic [TAG_BITS-1:0] tag;
    res      = '0;
    set_idx  = int'((acc.address >> OFF_BITS) & (NUM_SETS - 1));
    tag      = acc.address[ADDR_W-1:TAG_SHIFT];
    found    = 1'b0;
    way      = 0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found && shadow_valid[set_idx][w] && shadow_tag[set_idx][w] == tag) begin
        found = 1'b1;
        way   = w;
      end
    end
    if (found) begin
      res.hit                = 1'b1;
      res.next_level_request = salwc_pkg::REQ_NONE;
      if (acc.command == CMD_WRITE) begin
        shadow_dirty[set_idx][way] = 1'b1;
      end
      make_youngest(set_idx, way);
      n_hits++;
    end else begin
      res.next_level_request = salwc_pkg::REQ_READ;
      victim     = 0;
      have_empty = 1'b0;
      // A free way is always taken first, lowest index wins.
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (!have_empty && !shadow_valid[set_idx][w]) begin
          have_empty = 1'b1;
          victim     = w;
        end
      end
      if (!have_empty) begin
        // Full set: evict the oldest way; way 0 if somehow none is oldest.
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
          if (shadow_age[set_idx][w] == NUM_WAYS - 1) begin
            victim = w;
          end
        end
        if (shadow_dirty[set_idx][victim]) begin
          res.next_level_request = salwc_pkg::REQ_WB_READ;
          res.evict_address      = shadow_fill[set_idx][victim];
          n_wbacks++;
        end
      end
      shadow_tag[set_idx][victim]   = tag;
      shadow_fill[set_idx][victim]  = acc.address;
      shadow_valid[set_idx][victim] = 1'b1;
      shadow_dirty[set_idx][victim] = (acc.command == CMD_WRITE);
      make_youngest(set_idx, victim);
      n_fills++;
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] make_addr(logic [TAG_BITS-1:0] tag, int set_idx,
                                                  int offset);
    logic [ADDR_W-1:0] a;
    a = {tag, SET_BITS'(set_idx), OFF_BITS'(offset)};
    return a;
  endfunction

  // Idle rates in percent. The sender idles lightly while the receiver idles
  // heavily, then the roles swap, and the last stretch runs with no idling.
  function automatic int send_idle_pct(int count);
    if (count < 500) begin
      return 20;
    end else if (count < 1000) begin
      return 60;
    end
    return 0;
  endfunction

  function automatic int recv_idle_pct(int count);
    if (count < 500) begin
      return 60;
    end else if (count < 1000) begin
      return 20;
    end
    return 0;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver. Holds a transaction steady until the cache takes it; the shadow
  // model is stepped at the very edge on which the handshake completes, so
  // predictions are made in acceptance order.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        lookup_q.push_back(predict_lookup(pending_q[0]));
        void'(pending_q.pop_front());
        n_sent++;
      end
      if (in_if.valid && !in_if.ready) begin
        // Stalled: keep offering the same transaction.
      end else if (pending_q.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct(n_sent)) begin
        in_if.valid   <= 1'b1;
        in_if.command <= pending_q[0].command;
        in_if.address <= pending_q[0].address;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // One long hold-off early in the run, counted here: the sender keeps
  // offering, so the pipeline fills and the cache has to drop its input ready.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!held_off && n_rcvd >= HOLD_START) begin
        held_off  <= 1'b1;
        hold_left <= HOLD_CYCLES;
      end
    end
  end

  // Monitor. Each completed result transaction is checked field by field
  // against the oldest prediction, then the ready for the next edge is drawn.
  always @(posedge clk) begin
    lookup_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_rcvd++;
        if (lookup_q.size() == 0) begin
          $error("unexpected result: hit=%0d request=%0d evict=%h",
                 out_if.hit, out_if.next_level_request, out_if.evict_address);
          err_cnt++;
        end else begin
          want = lookup_q.pop_front();
          if (out_if.hit !== want.hit) begin
            $error("hit mismatch: expected %0d, got %0d", want.hit, out_if.hit);
            err_cnt++;
          end
          if (out_if.next_level_request !== want.next_level_request) begin
            $error("next_level_request mismatch: expected %0d, got %0d",
                   want.next_level_request, out_if.next_level_request);
            err_cnt++;
          end
          if (out_if.evict_address !== want.evict_address) begin
            $error("evict_address mismatch: expected %h, got %h",
                   want.evict_address, out_if.evict_address);
            err_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct(n_rcvd));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d predictions outstanding",
               cycle_cnt, lookup_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [TAG_BITS-1:0] tag_pool[4];
    logic [TAG_BITS-1:0] ones;
    access_t             acc;
    int                  pick;

    rst_n = 1'b0;

    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        shadow_valid[s][w] = 1'b0;
        shadow_dirty[s][w] = 1'b0;
        shadow_age[s][w]   = NUM_WAYS - 1;
      end
    end

    ones = '1;
    // Directed part. Set 0 walks through a read fill, a read hit, a write fill,
    // a write hit on a clean line, and then evictions of dirty and clean victims.
    // The dirty victim filled at address zero but was written at offset 8,
    // so the reported writeback must be the original fill address.
    pending_q.push_back('{CMD_READ,  make_addr('0, 0, 0)});
    pending_q.push_back('{CMD_WRITE, 32'hFFFF_FFFF});
    pending_q.push_back('{CMD_READ,  make_addr('0, 0, 4)});
    pending_q.push_back('{CMD_WRITE, make_addr(TAG_BITS'(1), 0, 15)});
    pending_q.push_back('{CMD_WRITE, make_addr('0, 0, 8)});
    pending_q.push_back('{CMD_READ,  make_addr(TAG_BITS'(2), 0, 0)});
    pending_q.push_back('{CMD_READ,  make_addr(TAG_BITS'(3), 0, 0)});
    pending_q.push_back('{CMD_READ,  make_addr(TAG_BITS'(4), 0, 0)});
    pending_q.push_back('{CMD_READ,  make_addr(TAG_BITS'(3), 0, 1)});
    pending_q.push_back('{CMD_READ,  make_addr(TAG_BITS'(5), 0, 2)});
    // Set 31 with the all-ones tag: a hit at another offset, a second fill, then two
    // dirty evictions, one of them at the all-ones fill address, and a clean one.
    pending_q.push_back('{CMD_READ,  32'hFFFF_FFF0});
    pending_q.push_back('{CMD_WRITE, make_addr('0, NUM_SETS - 1, 0)});
    pending_q.push_back('{CMD_READ,  make_addr(TAG_BITS'(5), NUM_SETS - 1, 7)});
    pending_q.push_back('{CMD_READ,  make_addr(TAG_BITS'(6), NUM_SETS - 1, 7)});
    pending_q.push_back('{CMD_WRITE, make_addr(ones, NUM_SETS - 1, 15)});
    // Alternating bit patterns touch both values of each address bit, and a
    // write hit after a read fill turns a clean line dirty.
    pending_q.push_back('{CMD_READ,  32'hAAAA_AAAA});
    pending_q.push_back('{CMD_READ,  32'h5555_5555});
    pending_q.push_back('{CMD_WRITE, 32'hAAAA_AAA0});
    pending_q.push_back('{CMD_READ,  32'hAAAA_AAAA ^ 32'h0100_0000});
    pending_q.push_back('{CMD_READ,  32'hAAAA_AAAA ^ 32'h0200_0000});

    // Random part. Most accesses draw their tag from a small pool, so sets
    // keep refilling and both hits and dirty evictions are common; the rest
    // are fully random addresses that nearly always miss.
    for (int i = 0; i < 4; i++) begin
      tag_pool[i] = TAG_BITS'($urandom);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      acc.command = 1'($urandom_range(1));
      if ($urandom_range(99) < 80) begin
        pick        = $urandom_range(3);
        acc.address = make_addr(tag_pool[pick], $urandom_range(NUM_SETS - 1),
                                $urandom_range((1 << OFF_BITS) - 1));
      end else begin
        acc.address = $urandom;
      end
      pending_q.push_back(acc);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every access to go in and every prediction to be matched,
    // then leave a drain period for any stray result to show up.
    while (pending_q.size() > 0 || lookup_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d accesses: %0d hits, %0d line fills, %0d dirty writebacks",
             n_sent, n_hits, n_fills, n_wbacks);
    $display("%0d results checked, including a %0d-cycle output stall", n_rcvd, HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
